FILE: design/fc8_pkg.sv
// ----------------------------------------------------------------------------
// fc8_pkg
// Shared types, constants and the byte-wide crc-8 step for the frame checker.
// ----------------------------------------------------------------------------
package fc8_pkg;

	localparam int unsigned LEN_W  = 4;
	localparam int unsigned BYTE_W = 8;

	localparam logic [BYTE_W-1:0] FRAME_MARKER = 8'h7E;
	localparam logic [BYTE_W-1:0] CRC_TOP_BIT  = 8'h80;
	localparam logic [BYTE_W-1:0] CRC_INIT     = 8'h00;
	localparam logic [BYTE_W-1:0] POLY_RESET   = 8'h07;

	// input word kind codes
	typedef enum logic {
		REQ_HEADER = 1'b0,
		REQ_DATA   = 1'b1
	} req_kind_t;

	// header byte order through the crc unit
	typedef enum logic [1:0] {
		HB_DEST = 2'd0,
		HB_SRC  = 2'd1,
		HB_LEN  = 2'd2,
		HB_TYPE = 2'd3
	} hdr_byte_t;

	// classified work word between front and back
	typedef struct packed {
		req_kind_t        kind;
		logic [1:0]       dest_addr;
		logic [1:0]       src_addr;
		logic [LEN_W-1:0] frame_length;
		logic [2:0]       frame_type;
		logic [7:0]       received_crc;
		logic             crc_enable;
		logic             marker_ok;
		logic             emit;
		logic             len_err;
		logic [7:0]       data_byte;
	} op_t;

	// result word
	typedef struct packed {
		logic [7:0] crc_value;
		logic       crc_match;
		logic       marker_ok;
		logic [2:0] frame_kind;
		logic       length_error;
	} res_t;

	// back end handshake toward the two queues
	typedef struct packed {
		logic op_pop;
		logic res_push;
	} bk_ctl_t;

	// one byte through an msb-first crc-8, eight shift steps
	function automatic logic [BYTE_W-1:0] crc_byte(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data,
		input logic [BYTE_W-1:0] poly
	);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if ((c & CRC_TOP_BIT) != CRC_INIT) begin
				c = (c << 1) ^ poly;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: design/fc8_queue.sv
// ----------------------------------------------------------------------------
// fc8_queue
// Small register queue; head word is visible while not empty.
// ----------------------------------------------------------------------------
module fc8_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: design/fc8_front.sv
// ----------------------------------------------------------------------------
// fc8_front
// Accepts input words, tracks frame boundaries and classifies each word.
// ----------------------------------------------------------------------------
module fc8_front
	import fc8_pkg::*;
#(
	parameter int unsigned MAX_DATA = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             req_type,
	input  logic [7:0]       start_marker,
	input  logic [1:0]       dest_addr,
	input  logic [1:0]       src_addr,
	input  logic [LEN_W-1:0] frame_length,
	input  logic [2:0]       frame_type,
	input  logic [7:0]       received_crc,
	input  logic             crc_enable,
	input  logic [7:0]       data_byte,
	output logic             op_push,
	output op_t              op
);

	logic             in_frame_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic             is_header;
	logic             len_err;
	logic             hdr_emit;
	logic             last_byte;

	assign is_header = (req_kind_t'(req_type) == REQ_HEADER);
	assign len_err   = (frame_length > LEN_W'(MAX_DATA));
	assign hdr_emit  = len_err || (frame_length == '0);
	assign last_byte = (bytes_left_q == LEN_W'(1));

	// classify the word
	always_comb begin
		op.kind         = req_kind_t'(req_type);
		op.dest_addr    = dest_addr;
		op.src_addr     = src_addr;
		op.frame_length = frame_length;
		op.frame_type   = frame_type;
		op.received_crc = received_crc;
		op.crc_enable   = crc_enable;
		op.marker_ok    = (start_marker == FRAME_MARKER);
		op.data_byte    = data_byte;
		op.emit         = is_header ? hdr_emit : last_byte;
		op.len_err      = is_header && len_err;
	end

	// data outside a frame is dropped here
	assign op_push = accept && (is_header || in_frame_q);

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			if (is_header) begin
				in_frame_q   <= !hdr_emit;
				bytes_left_q <= hdr_emit ? '0 : frame_length;
			end else if (in_frame_q) begin
				bytes_left_q <= bytes_left_q - 1'b1;
				if (last_byte) begin
					in_frame_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: design/fc8_back.sv
// ----------------------------------------------------------------------------
// fc8_back
// Runs classified words through the crc unit and builds result words.
// ----------------------------------------------------------------------------
module fc8_back
	import fc8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] poly,
	input  logic       op_valid,
	input  op_t        op,
	input  logic       res_full,
	output bk_ctl_t    ctl,
	output res_t       res
);

	logic [7:0] crc_q;
	logic [1:0] step_q;
	logic [7:0] held_crc_q;
	logic [2:0] held_kind_q;
	logic       held_marker_ok_q;
	logic       held_enable_q;

	logic       is_header;
	logic       final_step;
	logic       advance;
	logic [7:0] crc_in;
	logic [7:0] byte_in;
	logic [7:0] crc_next;
	logic [7:0] cmp_crc;
	logic       use_en;

	assign is_header = (op.kind == REQ_HEADER);

	// header bytes go one per cycle unless the final one waits on a full result queue, data is a single step
	always_comb begin
		case (hdr_byte_t'(step_q))
			HB_DEST: byte_in = {6'd0, op.dest_addr};
			HB_SRC:  byte_in = {6'd0, op.src_addr};
			HB_LEN:  byte_in = {{(8 - LEN_W){1'b0}}, op.frame_length};
			HB_TYPE: byte_in = {5'd0, op.frame_type};
			default: byte_in = CRC_INIT;
		endcase
		if (!is_header) begin
			byte_in = op.data_byte;
		end
	end

	assign crc_in     = (is_header && hdr_byte_t'(step_q) == HB_DEST) ? CRC_INIT : crc_q;
	assign crc_next   = crc_byte(crc_in, byte_in, poly);
	assign final_step = !is_header || (hdr_byte_t'(step_q) == HB_TYPE);
	assign advance    = op_valid && !(final_step && op.emit && res_full);

	assign ctl.op_pop   = advance && final_step;
	assign ctl.res_push = advance && final_step && op.emit;

	// result word, header fields come straight from the op on a header
	assign cmp_crc = is_header ? op.received_crc : held_crc_q;
	assign use_en  = is_header ? op.crc_enable : held_enable_q;
	always_comb begin
		res.crc_value    = use_en ? crc_next : CRC_INIT;
		res.crc_match    = (crc_next == cmp_crc);
		res.marker_ok    = is_header ? op.marker_ok : held_marker_ok_q;
		res.frame_kind   = is_header ? op.frame_type : held_kind_q;
		res.length_error = op.len_err;
	end

	// crc accumulator and header byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			step_q <= '0;
		end else if (advance) begin
			crc_q  <= crc_next;
			step_q <= final_step ? '0 : step_q + 1'b1;
		end
	end

	// header fields held for the data that follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_crc_q       <= '0;
			held_kind_q      <= '0;
			held_marker_ok_q <= 1'b0;
			held_enable_q    <= 1'b0;
		end else if (advance && is_header && final_step) begin
			held_crc_q       <= op.received_crc;
			held_kind_q      <= op.frame_type;
			held_marker_ok_q <= op.marker_ok;
			held_enable_q    <= op.crc_enable;
		end
	end

endmodule

FILE: design/frame_crc8_check_top.sv
// ----------------------------------------------------------------------------
// frame_crc8_check_top
// CRC-8 generation and check of a small link frame: header then data bytes.
// ----------------------------------------------------------------------------
// A front end takes one word per cycle while full is low, tracks frame
// boundaries and drops data bytes that arrive outside a frame; accepted work
// goes into a four-deep queue. The back end runs one byte per cycle through
// the shared crc-8 step while the result queue has room: a data word is a
// single byte, a header word its four masked header bytes in turn, so data
// streams at one word per cycle and the queue absorbs the extra header bytes
// in short bursts. Results wait in a two-deep queue and are read with pop
// while empty is low; the polynomial is written with polynomial_we.
// ----------------------------------------------------------------------------
module frame_crc8_check_top
	import fc8_pkg::*;
#(
	parameter int unsigned MAX_DATA = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             polynomial_we,
	input  logic [7:0]       polynomial,
	input  logic             push,
	output logic             full,
	input  logic             req_type,
	input  logic [7:0]       start_marker,
	input  logic [1:0]       dest_addr,
	input  logic [1:0]       src_addr,
	input  logic [LEN_W-1:0] frame_length,
	input  logic [2:0]       frame_type,
	input  logic [7:0]       received_crc,
	input  logic             crc_enable,
	input  logic [7:0]       data_byte,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       crc_value,
	output logic             crc_match,
	output logic             marker_ok,
	output logic [2:0]       frame_kind,
	output logic             length_error
);

	localparam int unsigned OP_DEPTH  = 4;
	localparam int unsigned RES_DEPTH = 2;

	logic [7:0] poly_q;
	logic       accept;
	logic       op_push;
	op_t        op_in;
	op_t        op_head;
	logic       op_empty;
	logic       op_full;
	bk_ctl_t    bk_ctl;
	res_t       res_in;
	res_t       res_head;
	logic       res_full;

	// polynomial register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
		end else if (polynomial_we) begin
			poly_q <= polynomial;
		end
	end

	assign full   = op_full;
	assign accept = push && !op_full;

	// front end
	fc8_front #(
		.MAX_DATA(MAX_DATA)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.start_marker (start_marker),
		.dest_addr    (dest_addr),
		.src_addr     (src_addr),
		.frame_length (frame_length),
		.frame_type   (frame_type),
		.received_crc (received_crc),
		.crc_enable   (crc_enable),
		.data_byte    (data_byte),
		.op_push      (op_push),
		.op           (op_in)
	);

	// work queue between front and back
	fc8_queue #(
		.WIDTH($bits(op_t)),
		.DEPTH(OP_DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (op_push),
		.wr_data (op_in),
		.rd_en   (bk_ctl.op_pop),
		.rd_data (op_head),
		.empty   (op_empty),
		.full    (op_full)
	);

	// back end
	fc8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.poly     (poly_q),
		.op_valid (!op_empty),
		.op       (op_head),
		.res_full (res_full),
		.ctl      (bk_ctl),
		.res      (res_in)
	);

	// result queue
	fc8_queue #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bk_ctl.res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty),
		.full    (res_full)
	);

	assign crc_value    = res_head.crc_value;
	assign crc_match    = res_head.crc_match;
	assign marker_ok    = res_head.marker_ok;
	assign frame_kind   = res_head.frame_kind;
	assign length_error = res_head.length_error;

`ifndef SYNTH
	// back end never writes a result into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		bk_ctl.res_push |-> !res_full)
		else $error("result written into full queue");

	// back end only retires work that is present
	a_op_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		bk_ctl.op_pop |-> !op_empty)
		else $error("work queue popped while empty");

	// front end never writes into a full work queue
	a_op_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		op_push |-> !op_full)
		else $error("work written into full queue");

	// a result is only produced when a word retires
	a_res_with_pop: assert property (@(posedge clk) disable iff (!arst_n)
		bk_ctl.res_push |-> bk_ctl.op_pop)
		else $error("result without retired word");
`endif

endmodule

FILE: test/tb_frame_crc8_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_crc8_check_top
// Self-checking bench for the frame crc-8 checker: directed and random frames
// pass through a queue-style driver; a scoreboard predicts each verdict word
// and the monitor compares it field by field over several polynomials.
// ----------------------------------------------------------------------------
module tb_frame_crc8_check_top
	import fc8_pkg::*;
();

	localparam int unsigned FRAME_MAX     = 15;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned REPORT_LIMIT  = 10;

	// one input word as offered to the block
	typedef struct {
		req_kind_t        kind;
		logic [7:0]       marker;
		logic [1:0]       dest;
		logic [1:0]       src;
		logic [LEN_W-1:0] len;
		logic [2:0]       ftype;
		logic [7:0]       rx_crc;
		logic             en;
		logic [7:0]       data;
	} frame_word_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             polynomial_we = 1'b0;
	logic [7:0]       polynomial    = POLY_RESET;
	logic             push          = 1'b0;
	logic             full;
	logic             req_type      = REQ_HEADER;
	logic [7:0]       start_marker  = 8'h00;
	logic [1:0]       dest_addr     = 2'd0;
	logic [1:0]       src_addr      = 2'd0;
	logic [LEN_W-1:0] frame_length  = '0;
	logic [2:0]       frame_type    = 3'd0;
	logic [7:0]       received_crc  = 8'h00;
	logic             crc_enable    = 1'b0;
	logic [7:0]       data_byte     = 8'h00;
	logic             empty;
	logic             pop           = 1'b0;
	logic [7:0]       crc_value;
	logic             crc_match;
	logic             marker_ok;
	logic [2:0]       frame_kind;
	logic             length_error;

	frame_word_t words_pending[$];
	frame_word_t word_on_bus;
	res_t        verdicts_due[$];

	// scoreboard copy of the block state and its polynomial
	logic [7:0]       poly_cur    = POLY_RESET;
	logic [7:0]       run_crc     = CRC_INIT;
	logic [LEN_W-1:0] bytes_rem   = '0;
	logic             frame_open  = 1'b0;
	logic [7:0]       hold_rx_crc = 8'h00;
	logic [2:0]       hold_kind   = 3'd0;
	logic             hold_marker = 1'b0;
	logic             hold_en     = 1'b0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned bad_count     = 0;
	int unsigned hold_req_seq  = 0;
	int unsigned hold_ack_seq  = 0;
	int unsigned hold_left     = 0;

	frame_crc8_check_top #(.MAX_DATA(FRAME_MAX)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.polynomial_we(polynomial_we),
		.polynomial   (polynomial),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.start_marker (start_marker),
		.dest_addr    (dest_addr),
		.src_addr     (src_addr),
		.frame_length (frame_length),
		.frame_type   (frame_type),
		.received_crc (received_crc),
		.crc_enable   (crc_enable),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.crc_value    (crc_value),
		.crc_match    (crc_match),
		.marker_ok    (marker_ok),
		.frame_kind   (frame_kind),
		.length_error (length_error)
	);

	always #2 clk = ~clk;

	// msb-first crc-8 over one byte
	function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ poly_cur) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	// the four masked header bytes, starting from zero
	function automatic logic [7:0] header_crc(logic [1:0] d, logic [1:0] s,
			logic [LEN_W-1:0] l, logic [2:0] t);
		logic [7:0] c;
		c = crc8_step(CRC_INIT, {6'd0, d});
		c = crc8_step(c, {6'd0, s});
		c = crc8_step(c, {4'd0, l});
		c = crc8_step(c, {5'd0, t});
		return c;
	endfunction

	// close the frame and queue its verdict
	task automatic post_verdict(logic len_err);
		res_t r;
		r.crc_value    = hold_en ? run_crc : CRC_INIT;
		r.crc_match    = (run_crc == hold_rx_crc);
		r.marker_ok    = hold_marker;
		r.frame_kind   = hold_kind;
		r.length_error = len_err;
		verdicts_due.push_back(r);
		frame_open = 1'b0;
		bytes_rem  = '0;
	endtask

	// frame tracking and crc for one accepted word
	task automatic frame_check_predict(frame_word_t w);
		if (w.kind == REQ_HEADER) begin
			hold_rx_crc = w.rx_crc;
			hold_en     = w.en;
			hold_kind   = w.ftype;
			hold_marker = (w.marker == FRAME_MARKER);
			run_crc     = header_crc(w.dest, w.src, w.len, w.ftype);
			if (w.len > FRAME_MAX) begin
				post_verdict(1'b1);
			end else if (w.len == 0) begin
				post_verdict(1'b0);
			end else begin
				bytes_rem  = w.len;
				frame_open = 1'b1;
			end
		end else if (frame_open) begin
			run_crc   = crc8_step(run_crc, w.data);
			bytes_rem = bytes_rem - 1'b1;
			if (bytes_rem == 0) begin
				post_verdict(1'b0);
			end
		end
	endtask

	// header word; the data field carries noise
	task automatic add_header(logic [1:0] d, logic [1:0] s, logic [LEN_W-1:0] l,
			logic [2:0] t, logic [7:0] m, logic [7:0] rx, logic e);
		frame_word_t w;
		w.kind   = REQ_HEADER;
		w.dest   = d;
		w.src    = s;
		w.len    = l;
		w.ftype  = t;
		w.marker = m;
		w.rx_crc = rx;
		w.en     = e;
		w.data   = 8'($urandom_range(255));
		words_pending.push_back(w);
	endtask

	// data word; the header fields carry noise
	task automatic add_data(logic [7:0] b);
		frame_word_t w;
		w.kind   = REQ_DATA;
		w.dest   = 2'($urandom_range(3));
		w.src    = 2'($urandom_range(3));
		w.len    = LEN_W'($urandom_range(15));
		w.ftype  = 3'($urandom_range(7));
		w.marker = 8'($urandom_range(255));
		w.rx_crc = 8'($urandom_range(255));
		w.en     = 1'($urandom_range(1));
		w.data   = b;
		words_pending.push_back(w);
	endtask

	// random frame of len bytes, of which only the first sent go out
	task automatic add_frame(int unsigned len, int unsigned sent);
		logic [7:0]       body [16];
		logic [7:0]       c;
		logic [7:0]       m;
		logic [1:0]       d;
		logic [1:0]       s;
		logic [2:0]       t;
		logic [LEN_W-1:0] l;
		d = 2'($urandom_range(3));
		s = 2'($urandom_range(3));
		t = 3'($urandom_range(7));
		l = LEN_W'(len);
		m = ($urandom_range(3) != 0) ? FRAME_MARKER : 8'($urandom_range(255));
		c = header_crc(d, s, l, t);
		for (int i = 0; i < len; i++) begin
			body[i] = 8'($urandom_range(255));
			c = crc8_step(c, body[i]);
		end
		if ($urandom_range(1) == 0) begin
			c = 8'($urandom_range(255));
		end
		add_header(d, s, l, t, m, c, 1'($urandom_range(1)));
		for (int i = 0; i < sent; i++) begin
			add_data(body[i]);
		end
	endtask

	// mostly whole frames, some cut short, some stray data
	task automatic add_random(int unsigned n);
		int unsigned counted;
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		counted = 0;
		while (counted < n) begin
			pick = $urandom_range(99);
			len  = $urandom_range(15);
			if (pick < 78) begin
				add_frame(len, len);
				counted += len + 1;
			end else if (pick < 90) begin
				cut = (len == 0) ? 0 : $urandom_range(len - 1);
				add_frame(len, cut);
				counted += cut + 1;
			end else begin
				add_data(8'($urandom_range(255)));
			end
		end
	endtask

	// extremes, every word kind and the frame corner cases
	task automatic add_directed();
		logic [7:0] c;
		// stray byte right after reset
		add_data(8'h5A);
		// zero-length frames, marker good and bad, crc on and off
		add_header(2'd0, 2'd0, 4'd0, 3'd0, FRAME_MARKER, 8'h00, 1'b1);
		add_header(2'd3, 2'd3, 4'd0, 3'd7, 8'h7F, 8'hFF, 1'b0);
		// one-byte frame with matching crc
		c = crc8_step(header_crc(2'd1, 2'd2, 4'd1, 3'd5), 8'hFF);
		add_header(2'd1, 2'd2, 4'd1, 3'd5, FRAME_MARKER, c, 1'b1);
		add_data(8'hFF);
		// frame abandoned by a new header
		add_header(2'd2, 2'd1, 4'd2, 3'd2, 8'hFF, 8'hFF, 1'b1);
		add_data(8'h00);
		add_header(2'd0, 2'd3, 4'd1, 3'd4, FRAME_MARKER, 8'h00, 1'b0);
		add_data(8'h80);
		// longest frame, then a stray byte after it
		add_header(2'd3, 2'd0, 4'd15, 3'd3, 8'h00, 8'hA5, 1'b1);
		for (int i = 0; i < 15; i++) begin
			add_data(8'((i * 37) ^ 8'hC3));
		end
		add_data(8'h01);
	endtask

	// sender waits for every outstanding verdict, then lets the core settle
	task automatic drain();
		@(negedge clk);
		while (words_pending.size() != 0 || push || verdicts_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_polynomial(logic [7:0] v);
		@(posedge clk);
		polynomial_we <= 1'b1;
		polynomial    <= v;
		@(posedge clk);
		polynomial_we <= 1'b0;
		poly_cur = v;
		@(negedge clk);
	endtask

	task automatic set_idling(int unsigned s_pct, int unsigned r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
	endtask

	// driver: offer one word at a time, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				frame_check_predict(word_on_bus);
			end
			if (!push || !full) begin
				if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					word_on_bus = words_pending.pop_front();
					push         <= 1'b1;
					req_type     <= word_on_bus.kind;
					start_marker <= word_on_bus.marker;
					dest_addr    <= word_on_bus.dest;
					src_addr     <= word_on_bus.src;
					frame_length <= word_on_bus.len;
					frame_type   <= word_on_bus.ftype;
					received_crc <= word_on_bus.rx_crc;
					crc_enable   <= word_on_bus.en;
					data_byte    <= word_on_bus.data;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// compare one popped verdict word with the oldest prediction
	task automatic check_verdict();
		res_t want;
		if (verdicts_due.size() == 0) begin
			bad_count++;
			if (bad_count <= REPORT_LIMIT) begin
				$display("ERROR: unexpected verdict crc=%02h match=%0b marker=%0b kind=%0d lerr=%0b",
					crc_value, crc_match, marker_ok, frame_kind, length_error);
			end
		end else begin
			want = verdicts_due.pop_front();
			if (crc_value !== want.crc_value || crc_match !== want.crc_match ||
					marker_ok !== want.marker_ok || frame_kind !== want.frame_kind ||
					length_error !== want.length_error) begin
				bad_count++;
				if (bad_count <= REPORT_LIMIT) begin
					$display("ERROR: verdict at %0t exp crc=%02h match=%0b marker=%0b kind=%0d lerr=%0b",
						$realtime, want.crc_value, want.crc_match, want.marker_ok,
						want.frame_kind, want.length_error);
					$display("       got crc=%02h match=%0b marker=%0b kind=%0d lerr=%0b",
						crc_value, crc_match, marker_ok, frame_kind, length_error);
				end
			end
		end
	endtask

	// monitor: random pop with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop          <= 1'b0;
			hold_left    <= 0;
			hold_ack_seq <= 0;
		end else begin
			if (pop && !empty) begin
				check_verdict();
			end
			if (hold_ack_seq != hold_req_seq) begin
				hold_ack_seq <= hold_req_seq;
				hold_left    <= LONG_HOLD;
				pop          <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				pop       <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset polynomial, slow receiver
		load_polynomial(POLY_RESET);
		set_idling(14, 62);
		add_directed();
		add_random(130);
		drain();

		load_polynomial(8'h00);
		add_random(70);
		drain();

		// slow sender
		load_polynomial(8'hFF);
		set_idling(62, 14);
		add_random(140);
		drain();

		load_polynomial(8'($urandom_range(255)));
		add_random(100);
		drain();

		// no idling; receiver stalls long so the input backs up
		load_polynomial(8'h31);
		set_idling(0, 0);
		hold_req_seq <= hold_req_seq + 1;
		add_random(130);
		drain();

		load_polynomial(8'h80);
		add_random(130);
		drain();

		if (bad_count == 0 && verdicts_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/fc8_pkg.sv
design/fc8_queue.sv
design/fc8_front.sv
design/fc8_back.sv
design/frame_crc8_check_top.sv
test/tb_frame_crc8_check_top.sv
